@@ src/dhfd_pkg.sv @@
// ----------------------------------------------------------------------------
// dhfd_pkg
// Shared constants and decode helpers for the deinterleaving SECDED frame
// decoder: section geometry, store sizing and the extended Hamming(8,4) masks.
// ----------------------------------------------------------------------------
`default_nettype none

package dhfd_pkg;

    localparam int FIRST_LEN    = 7;
    localparam int FIRST_DEPTH  = 7;
    localparam int SECOND_LEN   = 26;
    localparam int SECOND_DEPTH = 13;
    localparam int TOTAL_LEN    = FIRST_LEN + SECOND_LEN;

    localparam int ADDR_W = $clog2(TOTAL_LEN);
    localparam int POS_W  = 6;
    localparam int IDX_W  = 7;
    localparam int BLK_W  = 5;
    localparam int BASE_W = 6;
    localparam int ERR_W  = 6;

    localparam logic [IDX_W-1:0]  FIRST_LEN_V    = IDX_W'(FIRST_LEN);
    localparam logic [IDX_W-1:0]  FIRST_DEPTH_V  = IDX_W'(FIRST_DEPTH);
    localparam logic [IDX_W-1:0]  SECOND_LEN_V   = IDX_W'(SECOND_LEN);
    localparam logic [IDX_W-1:0]  SECOND_DEPTH_V = IDX_W'(SECOND_DEPTH);
    localparam logic [IDX_W-1:0]  TOTAL_LEN_V    = IDX_W'(TOTAL_LEN);
    localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(TOTAL_LEN - 1);
    localparam logic [ERR_W-1:0]  ERR_MAX        = '1;

    localparam logic [7:0] MASK_P1  = 8'haa;
    localparam logic [7:0] MASK_P2  = 8'h66;
    localparam logic [7:0] MASK_P4  = 8'h1e;
    localparam logic [7:0] MASK_ALL = 8'hff;
    localparam logic [7:0] MASK_P8  = 8'h01;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_BIT_RD = 5'b00010,
        ST_BIT_WR = 5'b00100,
        ST_DEC_RD = 5'b01000,
        ST_DEC_LD = 5'b10000
    } state_t;

    function automatic logic [2:0] syndrome(input logic [7:0] b);
        syndrome = {^(b & MASK_P4), ^(b & MASK_P2), ^(b & MASK_P1)};
    endfunction

    function automatic logic [7:0] flip_mask(input logic [2:0] s);
        case (s)
            3'd1:    flip_mask = 8'h80;
            3'd2:    flip_mask = 8'h40;
            3'd3:    flip_mask = 8'h20;
            3'd4:    flip_mask = 8'h10;
            3'd5:    flip_mask = 8'h08;
            3'd6:    flip_mask = 8'h04;
            3'd7:    flip_mask = 8'h02;
            default: flip_mask = MASK_P8;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ src/dhfd_ram.sv @@
// ----------------------------------------------------------------------------
// dhfd_ram
// Generic single-port RAM with one shared address and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dhfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        rd_data <= mem_reg[addr];
    end

endmodule

`default_nettype wire

@@ src/deinterleave_hamming84_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// deinterleave_hamming84_frame_decoder
// Block bit deinterleaver into a frame store, then extended Hamming(8,4)
// SECDED correction of every stored codeword.
//
// The input channel (s_valid/s_ready) takes one interleaved code byte per
// request; s_frame_start marks the first byte of a frame. Once a byte is
// accepted, its eight bits are scattered into the frame store one at a time,
// each by a read-modify-write (ST_BIT_RD, then ST_BIT_WR) on the single store
// port, with s_ready low until the last bit of the byte is written.
// After the last byte of the frame the block decodes the store in order and
// sends one request per codeword on the result channel (m_valid/m_ready).
// Each result passes through a store read (ST_DEC_RD), then a decode into the
// output register (ST_DEC_LD).
// A stalled receiver holds the output register and the decode sequence waits
// on it; no new byte is taken until the last result is in the output register.
// Reset clears the sequencer, the frame position, the error count and the
// failure flag; the frame store needs no clearing, since every codeword is
// fully written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module deinterleave_hamming84_frame_decoder
    import dhfd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_code_byte,
    input  wire logic             s_frame_start,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [7:0]       m_fixed_byte,
    output logic      [3:0]       m_data_nibble,
    output logic                  m_section_id,
    output logic                  m_byte_fixed,
    output logic      [ERR_W-1:0] m_error_total,
    output logic                  m_frame_status,
    output logic                  m_last_result
);

    state_t            state_reg, state_next;
    logic [7:0]        code_reg, code_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [BLK_W-1:0]  r_reg, r_next;
    logic              first_reg, first_next;
    logic [2:0]        bit_reg, bit_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic              fail_reg, fail_next;
    logic              out_valid_reg, out_valid_next;

    logic [7:0]        out_byte_reg;
    logic              out_sec_reg;
    logic              out_fixed_reg;
    logic [ERR_W-1:0]  out_err_reg;
    logic              out_fail_reg;
    logic              out_last_reg;

    logic              sec;
    logic [IDX_W-1:0]  depth, len, off, idx, st_sum;
    logic              in_range;
    logic              bit_val;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              load_out;
    logic [2:0]        dec_s;
    logic              dec_p;
    logic [7:0]        dec_byte;
    logic              dec_flip;
    logic [ERR_W-1:0]  dec_err;
    logic              dec_fail;

    assign sec      = {1'b0, pos_reg} >= FIRST_LEN_V;
    assign depth    = sec ? SECOND_DEPTH_V : FIRST_DEPTH_V;
    assign len      = sec ? SECOND_LEN_V : FIRST_LEN_V;
    assign off      = sec ? FIRST_LEN_V : '0;
    assign idx      = {1'b0, base_reg} + {2'b0, r_reg};
    assign st_sum   = off + idx;
    assign in_range = idx < len;
    assign bit_val  = code_reg[~bit_reg];

    assign ram_we    = (state_reg == ST_BIT_WR) && in_range;
    assign ram_wdata = first_reg ? {7'b0, bit_val} : {ram_rdata[6:0], bit_val};
    assign ram_addr  = ((state_reg == ST_DEC_RD) || (state_reg == ST_DEC_LD)) ?
                       k_reg : st_sum[ADDR_W-1:0];

    dhfd_ram #(
        .WIDTH (8),
        .DEPTH (TOTAL_LEN)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    assign dec_s    = syndrome(ram_rdata);
    assign dec_p    = ^(ram_rdata & MASK_ALL);
    assign dec_flip = dec_p;
    assign dec_byte = dec_p ? (ram_rdata ^ flip_mask(dec_s)) : ram_rdata;
    assign dec_err  = (dec_p && (err_reg != ERR_MAX)) ? err_reg + 1'b1 : err_reg;
    assign dec_fail = fail_reg | (!dec_p && (dec_s != 3'd0));

    assign load_out = (state_reg == ST_DEC_LD) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        pos_next       = pos_reg;
        blk_next       = blk_reg;
        base_next      = base_reg;
        r_next         = r_reg;
        first_next     = first_reg;
        bit_next       = bit_reg;
        k_next         = k_reg;
        err_next       = err_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    code_next  = s_code_byte;
                    bit_next   = '0;
                    state_next = ST_BIT_RD;
                    if (s_frame_start || (pos_reg == '0)) begin
                        pos_next   = '0;
                        blk_next   = '0;
                        base_next  = '0;
                        r_next     = '0;
                        first_next = 1'b1;
                        err_next   = '0;
                        fail_next  = 1'b0;
                    end
                end
            end
            ST_BIT_RD: begin
                state_next = ST_BIT_WR;
            end
            ST_BIT_WR: begin
                bit_next   = bit_reg + 3'd1;
                state_next = ST_BIT_RD;
                if ({2'b0, r_reg} == depth - 1'b1) begin
                    r_next     = '0;
                    first_next = 1'b0;
                end else begin
                    r_next = r_reg + 1'b1;
                end
                if (bit_reg == 3'd7) begin
                    if ({1'b0, pos_reg} == FIRST_LEN_V - 1'b1) begin
                        blk_next   = '0;
                        base_next  = '0;
                        r_next     = '0;
                        first_next = 1'b1;
                    end else if ({2'b0, blk_reg} + 1'b1 == depth) begin
                        blk_next   = '0;
                        base_next  = base_reg + depth[BASE_W-1:0];
                        r_next     = '0;
                        first_next = 1'b1;
                    end else begin
                        blk_next = blk_reg + 1'b1;
                    end
                    if ({1'b0, pos_reg} + 1'b1 < TOTAL_LEN_V) begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = '0;
                        k_next     = '0;
                        state_next = ST_DEC_RD;
                    end
                end
            end
            ST_DEC_RD: begin
                state_next = ST_DEC_LD;
            end
            ST_DEC_LD: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    err_next       = dec_err;
                    fail_next      = dec_fail;
                    k_next         = k_reg + 1'b1;
                    state_next     = (k_reg == LAST_ADDR) ? ST_IDLE : ST_DEC_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            blk_reg       <= '0;
            base_reg      <= '0;
            r_reg         <= '0;
            first_reg     <= 1'b1;
            bit_reg       <= '0;
            k_reg         <= '0;
            err_reg       <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            blk_reg       <= blk_next;
            base_reg      <= base_next;
            r_reg         <= r_next;
            first_reg     <= first_next;
            bit_reg       <= bit_next;
            k_reg         <= k_next;
            err_reg       <= err_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        if (load_out) begin
            out_byte_reg  <= dec_byte;
            out_sec_reg   <= k_reg >= ADDR_W'(FIRST_LEN);
            out_fixed_reg <= dec_flip;
            out_err_reg   <= dec_err;
            out_fail_reg  <= dec_fail;
            out_last_reg  <= (k_reg == LAST_ADDR);
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_fixed_byte   = out_byte_reg;
    assign m_data_nibble  = out_byte_reg[7:4];
    assign m_section_id   = out_sec_reg;
    assign m_byte_fixed   = out_fixed_reg;
    assign m_error_total  = out_err_reg;
    assign m_frame_status = out_fail_reg;
    assign m_last_result  = out_last_reg;

`ifndef SYNTHESIS
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while a byte is in progress");

    a_no_store_write_in_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DEC_RD) || (state_reg == ST_DEC_LD)) |-> !ram_we)
        else $error("frame store written during decode");

    a_fixed_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_fixed) |-> (m_error_total != '0))
        else $error("corrected codeword not counted");

    a_last_in_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> m_section_id)
        else $error("final result not in the second section");
`endif

endmodule

`default_nettype wire

@@ bench/deinterleave_hamming84_frame_checker.sv @@
// ----------------------------------------------------------------------------
// deinterleave_hamming84_frame_checker
// Watches both channels of the frame decoder. Every accepted code byte is
// deinterleaved into a private frame store. On the last byte of a frame, each
// codeword is decoded with SECDED into an expected decoded word. Every result
// request is then compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module deinterleave_hamming84_frame_checker
    import dhfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [7:0]       s_code_byte,
    input  logic             s_frame_start,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [7:0]       m_fixed_byte,
    input  logic [3:0]       m_data_nibble,
    input  logic             m_section_id,
    input  logic             m_byte_fixed,
    input  logic [ERR_W-1:0] m_error_total,
    input  logic             m_frame_status,
    input  logic             m_last_result,
    output int               fail_count,
    output int               pending,
    output int               words_checked,
    output int               words_corrected,
    output int               frames_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       fixed_byte;
        logic [3:0]       data_nibble;
        logic             section_id;
        logic             byte_fixed;
        logic [ERR_W-1:0] error_total;
        logic             frame_status;
        logic             last_result;
    } decoded_word_t;

    decoded_word_t    expected_words[$];
    decoded_word_t    want;
    logic [7:0]       frame_store[TOTAL_LEN];
    logic [POS_W-1:0] byte_pos = '0;
    logic [ERR_W-1:0] err_count = '0;
    logic             fail_seen = 1'b0;
    int               mismatches = 0;
    int               checked = 0;
    int               corrected = 0;
    int               flagged = 0;

    initial begin
        fail_count      = 0;
        pending         = 0;
        words_checked   = 0;
        words_corrected = 0;
        frames_flagged  = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        if (mismatches < 40) begin
            $display("[%0t] word %0d, %s: got 0x%0h, expected 0x%0h",
                     $realtime, checked, what, got, exp_val);
        end
        mismatches++;
    endtask

    task automatic absorb_code_byte(input logic [7:0] code, input logic start);
        int            sec_off;
        int            sec_len;
        int            sec_depth;
        int            i;
        int            idx;
        logic [7:0]    word;
        logic [2:0]    syn;
        decoded_word_t res;

        if (start || byte_pos == 0) begin
            foreach (frame_store[k]) frame_store[k] = 8'h00;
            byte_pos  = '0;
            err_count = '0;
            fail_seen = 1'b0;
        end
        if (byte_pos < FIRST_LEN) begin
            i = byte_pos;
            sec_off = 0;
            sec_len = FIRST_LEN;
            sec_depth = FIRST_DEPTH;
        end else begin
            i = byte_pos - FIRST_LEN;
            sec_off = FIRST_LEN;
            sec_len = SECOND_LEN;
            sec_depth = SECOND_DEPTH;
        end
        for (int j = 0; j < 8; j++) begin
            idx = (i * 8 + j) % sec_depth + (i - i % sec_depth);
            if (idx < sec_len) begin
                frame_store[sec_off + idx] = {frame_store[sec_off + idx][6:0], code[7 - j]};
            end
        end
        if (byte_pos + 1 < TOTAL_LEN) begin
            byte_pos = byte_pos + 1'b1;
            return;
        end
        byte_pos = '0;

        for (int k = 0; k < TOTAL_LEN; k++) begin
            word = frame_store[k];
            syn  = {^(word & MASK_P4), ^(word & MASK_P2), ^(word & MASK_P1)};
            res.fixed_byte = word;
            res.byte_fixed = 1'b0;
            if (^(word & MASK_ALL)) begin
                res.fixed_byte = word ^ ((syn == 3'd0) ? MASK_P8 : (8'h80 >> (syn - 1)));
                res.byte_fixed = 1'b1;
                if (err_count != ERR_MAX) err_count = err_count + 1'b1;
            end else if (syn != 3'd0) begin
                fail_seen = 1'b1;
            end
            res.data_nibble  = res.fixed_byte[7:4];
            res.section_id   = (k >= FIRST_LEN);
            res.error_total  = err_count;
            res.frame_status = fail_seen;
            res.last_result  = (k == TOTAL_LEN - 1);
            expected_words.push_back(res);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos  = '0;
            err_count = '0;
            fail_seen = 1'b0;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) absorb_code_byte(s_code_byte, s_frame_start);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_fixed_byte, 8'h00);
                end else begin
                    want = expected_words.pop_front();
                    if (m_fixed_byte !== want.fixed_byte)
                        report_mismatch("fixed_byte", m_fixed_byte, want.fixed_byte);
                    if (m_data_nibble !== want.data_nibble)
                        report_mismatch("data_nibble", m_data_nibble, want.data_nibble);
                    if (m_section_id !== want.section_id)
                        report_mismatch("section_id", m_section_id, want.section_id);
                    if (m_byte_fixed !== want.byte_fixed)
                        report_mismatch("byte_fixed", m_byte_fixed, want.byte_fixed);
                    if (m_error_total !== want.error_total)
                        report_mismatch("error_total", m_error_total, want.error_total);
                    if (m_frame_status !== want.frame_status)
                        report_mismatch("frame_status", m_frame_status, want.frame_status);
                    if (m_last_result !== want.last_result)
                        report_mismatch("last_result", m_last_result, want.last_result);
                end
                checked++;
                if (m_byte_fixed) corrected++;
                if (m_last_result && m_frame_status) flagged++;
            end
        end
        fail_count      <= mismatches;
        pending         <= expected_words.size();
        words_checked   <= checked;
        words_corrected <= corrected;
        frames_flagged  <= flagged;
    end

endmodule

@@ bench/tb_deinterleave_hamming84_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_deinterleave_hamming84_frame_decoder
// Builds frames of SECDED codewords with chosen single and double bit errors,
// interleaves them per section and sends them as code bytes in random bursts,
// along with abandoned partial frames and pure noise frames. The receiver
// stalls on its own random pattern. The checker beside the block predicts and
// compares every decoded word; this module paces the run and gives a verdict.
// ----------------------------------------------------------------------------
module tb_deinterleave_hamming84_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import dhfd_pkg::*;

    localparam int ITEMS_TARGET = 230;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum {
        FK_CLEAN,
        FK_LIGHT,
        FK_MIXED,
        FK_HEAVY,
        FK_DOUBLE,
        FK_NOISE,
        FK_PARTIAL
    } frame_kind_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_code_byte = 8'h00;
    logic             s_frame_start = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_fixed_byte;
    logic [3:0]       m_data_nibble;
    logic             m_section_id;
    logic             m_byte_fixed;
    logic [ERR_W-1:0] m_error_total;
    logic             m_frame_status;
    logic             m_last_result;

    int fail_count;
    int pending;
    int words_checked;
    int words_corrected;
    int frames_flagged;

    logic [7:0] clean_words[16];
    logic [7:0] frame_words[TOTAL_LEN];
    int         items_sent = 0;
    int         frames_sent = 0;
    int         burst_left = 1;
    int         idle_count = 0;
    int         ready_left = 0;
    logic       ready_now = 1'b1;

    deinterleave_hamming84_frame_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fixed_byte   (m_fixed_byte),
        .m_data_nibble  (m_data_nibble),
        .m_section_id   (m_section_id),
        .m_byte_fixed   (m_byte_fixed),
        .m_error_total  (m_error_total),
        .m_frame_status (m_frame_status),
        .m_last_result  (m_last_result)
    );

    deinterleave_hamming84_frame_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_byte     (s_code_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fixed_byte    (m_fixed_byte),
        .m_data_nibble   (m_data_nibble),
        .m_section_id    (m_section_id),
        .m_byte_fixed    (m_byte_fixed),
        .m_error_total   (m_error_total),
        .m_frame_status  (m_frame_status),
        .m_last_result   (m_last_result),
        .fail_count      (fail_count),
        .pending         (pending),
        .words_checked   (words_checked),
        .words_corrected (words_corrected),
        .frames_flagged  (frames_flagged)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            if (ready_now && $urandom_range(3) != 0) begin
                ready_now  = 1'b0;
                ready_left = $urandom_range(1, 8);
            end else begin
                ready_now  = 1'b1;
                ready_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            end
        end
        ready_left--;
        m_ready <= ready_now;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("No request accepted for %0d cycles, giving up.", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic send_byte(input logic [7:0] code, input logic start);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_code_byte   <= code;
        s_frame_start <= start;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge aclk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
        end
    endtask

    function automatic logic [7:0] make_word(input int single_pct, input int double_pct);
        logic [7:0] w;
        int         r;
        int         b1;
        int         b2;

        w  = clean_words[$urandom_range(15)];
        r  = $urandom_range(99);
        b1 = $urandom_range(7);
        b2 = (b1 + $urandom_range(1, 7)) % 8;
        if (r < single_pct) begin
            w[b1] = ~w[b1];
        end else if (r < single_pct + double_pct) begin
            w[b1] = ~w[b1];
            w[b2] = ~w[b2];
        end
        return w;
    endfunction

    task automatic send_frame(input logic first_start, input int nbytes);
        int         arrived[TOTAL_LEN];
        logic [7:0] code[TOTAL_LEN];
        int         off;
        int         len;
        int         depth;
        int         idx;

        foreach (arrived[k]) arrived[k] = 0;
        for (int sec = 0; sec < 2; sec++) begin
            off   = (sec == 0) ? 0 : FIRST_LEN;
            len   = (sec == 0) ? FIRST_LEN : SECOND_LEN;
            depth = (sec == 0) ? FIRST_DEPTH : SECOND_DEPTH;
            for (int i = 0; i < len; i++) begin
                for (int j = 0; j < 8; j++) begin
                    idx = (i * 8 + j) % depth + (i - i % depth);
                    if (idx < len) begin
                        code[off + i][7 - j] = frame_words[off + idx][7 - arrived[off + idx]];
                        arrived[off + idx]++;
                    end else begin
                        code[off + i][7 - j] = 1'($urandom_range(1));
                    end
                end
            end
        end
        for (int b = 0; b < nbytes; b++) begin
            send_byte(code[b], (b == 0) ? first_start : 1'b0);
        end
    endtask

    initial begin
        int          n;
        int          r;
        int          single_pct;
        int          double_pct;
        logic        force_start;
        frame_kind_t kind;
        logic [7:0]  cand;

        n = 0;
        for (int v = 0; v < 256; v++) begin
            cand = 8'(v);
            if (!(^(cand & MASK_P1)) && !(^(cand & MASK_P2)) && !(^(cand & MASK_P4))
                && !(^(cand & MASK_ALL))) begin
                clean_words[n] = cand;
                n++;
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A frame abandoned after three bytes must leave nothing behind.
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'ha5, 1'b0);

        // Directed frame: all-zero and all-one codewords, a single error on
        // every bit position, double errors in the second section, and every nibble.
        frame_words[0] = 8'h00;
        frame_words[1] = 8'hff;
        for (int k = 2; k < 10; k++) frame_words[k] = clean_words[k] ^ (8'h80 >> (k - 2));
        frame_words[10] = clean_words[5] ^ 8'h81;
        for (int k = 11; k < TOTAL_LEN; k++) frame_words[k] = clean_words[k % 16];
        frame_words[20] = clean_words[9] ^ 8'h18;
        frame_words[TOTAL_LEN - 1] = clean_words[15] ^ 8'h01;
        send_frame(1'b1, TOTAL_LEN);
        frames_sent++;

        force_start = 1'b0;
        while (items_sent < ITEMS_TARGET) begin
            r = $urandom_range(99);
            if (r < 15)      kind = FK_CLEAN;
            else if (r < 35) kind = FK_LIGHT;
            else if (r < 55) kind = FK_MIXED;
            else if (r < 70) kind = FK_HEAVY;
            else if (r < 80) kind = FK_DOUBLE;
            else if (r < 88) kind = FK_NOISE;
            else             kind = FK_PARTIAL;
            if (kind == FK_PARTIAL && items_sent > ITEMS_TARGET - 40) kind = FK_LIGHT;

            case (kind)
                FK_CLEAN:  begin single_pct = 0;  double_pct = 0;  end
                FK_LIGHT:  begin single_pct = 8;  double_pct = 0;  end
                FK_MIXED:  begin single_pct = 25; double_pct = 4;  end
                FK_HEAVY:  begin single_pct = 80; double_pct = 0;  end
                FK_DOUBLE: begin single_pct = 20; double_pct = 20; end
                default:   begin single_pct = 0;  double_pct = 0;  end
            endcase
            foreach (frame_words[k]) begin
                frame_words[k] = (kind == FK_NOISE || kind == FK_PARTIAL)
                                 ? 8'($urandom_range(255))
                                 : make_word(single_pct, double_pct);
            end

            if (kind == FK_PARTIAL) begin
                send_frame(force_start ? 1'b1 : 1'($urandom_range(1)),
                           $urandom_range(1, TOTAL_LEN - 1));
                force_start = 1'b1;
            end else begin
                send_frame(force_start ? 1'b1 : 1'($urandom_range(1)), TOTAL_LEN);
                force_start = 1'b0;
                frames_sent++;
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d code bytes, %0d complete frames, %0d decoded words checked.",
                 items_sent, frames_sent, words_checked);
        $display("Of those, %0d words were corrected and %0d frames were uncorrectable.",
                 words_corrected, frames_flagged);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ deinterleave_hamming84_frame_decoder.f @@
src/dhfd_pkg.sv
src/dhfd_ram.sv
src/deinterleave_hamming84_frame_decoder.sv
bench/deinterleave_hamming84_frame_checker.sv
bench/tb_deinterleave_hamming84_frame_decoder.sv
